// ----- rtl/vcg_pkg.sv -----
`default_nettype none
package vcg_pkg;

    localparam int unsigned MAX_GLYPHS_DEF = 65536;

    localparam int IDX_W      = 16;
    localparam int SLOT_W     = 18;
    localparam int COORD_W    = 32;
    localparam int SIZE_W     = 31;
    localparam int SQ_W       = 64;
    localparam int ROOT_W     = 32;
    localparam int SREM_W     = 34;
    localparam int NUM_W      = 62;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    localparam logic [0:0] CFG_SIZE_FACTOR = 1'b0;
    localparam logic [0:0] CFG_OFFSET_MODE = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]                idx;
        logic [2:0][COORD_W-1:0]         pnt;
        logic [2:0]                      sgn;
        logic [2:0][COORD_W-1:0]         mag;
        logic                            deg;
        logic [ROOT_W-1:0]               div;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]                idx;
        logic [2:0][COORD_W-1:0]         pnt;
        logic [2:0][COORD_W-1:0]         ofs;
        logic                            deg;
    } glyph_t;

endpackage
`default_nettype wire

// ----- rtl/vcg_sqrt_cell.sv -----
`default_nettype none
module vcg_sqrt_cell (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [vcg_pkg::SQ_W-1:0]     x_in,
    input  wire logic [vcg_pkg::SREM_W-1:0]   rem_in,
    input  wire logic [vcg_pkg::ROOT_W-1:0]   root_in,
    output logic      [vcg_pkg::SQ_W-1:0]     x_reg,
    output logic      [vcg_pkg::SREM_W-1:0]   rem_reg,
    output logic      [vcg_pkg::ROOT_W-1:0]   root_reg
);

    localparam int T_W = vcg_pkg::SREM_W + 2;

    logic [T_W-1:0] t;
    logic [T_W-1:0] trial;
    logic           ge;

    always_comb begin
        t     = {rem_in, x_in[vcg_pkg::SQ_W-1 -: 2]};
        trial = {2'b00, root_in, 2'b01};
        ge    = (t >= trial);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= {x_in[vcg_pkg::SQ_W-3:0], 2'b00};
            rem_reg  <= ge ? vcg_pkg::SREM_W'(t - trial) : t[vcg_pkg::SREM_W-1:0];
            root_reg <= {root_in[vcg_pkg::ROOT_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vcg_div_cell.sv -----
`default_nettype none
module vcg_div_cell (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [vcg_pkg::ROOT_W-1:0]   m_in,
    input  wire logic [vcg_pkg::ROOT_W-1:0]   rem_in,
    input  wire logic [vcg_pkg::SIZE_W-1:0]   num_in,
    input  wire logic [vcg_pkg::SIZE_W-1:0]   q_in,
    output logic      [vcg_pkg::ROOT_W-1:0]   rem_reg,
    output logic      [vcg_pkg::SIZE_W-1:0]   num_reg,
    output logic      [vcg_pkg::SIZE_W-1:0]   q_reg
);

    logic [vcg_pkg::ROOT_W:0] t;
    logic [vcg_pkg::ROOT_W:0] dv;
    logic                     ge;

    always_comb begin
        t  = {rem_in, num_in[vcg_pkg::SIZE_W-1]};
        dv = {1'b0, m_in};
        ge = (t >= dv);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= ge ? vcg_pkg::ROOT_W'(t - dv) : t[vcg_pkg::ROOT_W-1:0];
            num_reg <= {num_in[vcg_pkg::SIZE_W-2:0], 1'b0};
            q_reg   <= {q_in[vcg_pkg::SIZE_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vcg_emit.sv -----
`default_nettype none
module vcg_emit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire vcg_pkg::glyph_t               in_glyph,
    input  wire logic [vcg_pkg::SIZE_W-1:0]    size_factor,
    input  wire logic                          offset_mode,
    output logic                               load,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [vcg_pkg::SLOT_W-1:0]         m_vertex_slot,
    output logic signed [vcg_pkg::COORD_W-1:0] m_vertex_x,
    output logic signed [vcg_pkg::COORD_W-1:0] m_vertex_y,
    output logic signed [vcg_pkg::COORD_W-1:0] m_vertex_z,
    output logic [vcg_pkg::SIZE_W-1:0]         m_vertex_radius,
    output logic                               m_last_vertex
);

    localparam int S_W = vcg_pkg::COORD_W + 2;

    vcg_pkg::glyph_t g_reg;
    logic            vld_reg;
    logic [1:0]      k_reg;

    logic [2:0][vcg_pkg::COORD_W-1:0] vtx;

    always_comb begin
        load = !vld_reg || (m_ready && k_reg == 2'd3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            k_reg   <= 2'd0;
        end else if (load) begin
            vld_reg <= in_valid;
            k_reg   <= 2'd0;
        end else if (m_ready) begin
            k_reg   <= k_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            g_reg <= in_glyph;
        end
    end

    always_comb begin
        logic signed [S_W-1:0] p;
        logic signed [S_W-1:0] o;
        logic signed [S_W-1:0] term;
        logic signed [S_W-1:0] s;
        for (int c = 0; c < 3; c++) begin
            p = S_W'($signed(g_reg.pnt[c]));
            o = S_W'($signed(g_reg.ofs[c]));
            term = '0;
            if (!offset_mode) begin
                unique case (k_reg)
                    2'd0:    term = o;
                    2'd3:    term = -o;
                    default: term = '0;
                endcase
            end else begin
                unique case (k_reg)
                    2'd0:    term = '0;
                    2'd3:    term = -(o <<< 1);
                    default: term = -o;
                endcase
            end
            s = g_reg.deg ? p : p + term;
            if (s > S_W'(32'sh7FFF_FFFF)) begin
                vtx[c] = 32'h7FFF_FFFF;
            end else if (s < -S_W'(35'sh8000_0000)) begin
                vtx[c] = 32'h8000_0000;
            end else begin
                vtx[c] = s[vcg_pkg::COORD_W-1:0];
            end
        end
    end

    always_comb begin
        m_valid       = vld_reg;
        m_vertex_slot = {g_reg.idx, k_reg};
        m_vertex_x    = $signed(vtx[0]);
        m_vertex_y    = $signed(vtx[1]);
        m_vertex_z    = $signed(vtx[2]);
        m_last_vertex = (k_reg == 2'd3);
        if (g_reg.deg) begin
            m_vertex_radius = '0;
        end else begin
            unique case (k_reg)
                2'd2:    m_vertex_radius = size_factor >> 2;
                2'd3:    m_vertex_radius = '0;
                default: m_vertex_radius = size_factor >> 3;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vector_cone_glyph_generator.sv -----
// Vertices leave the result port one per cycle while m_ready stays high.
// The four vertices of each glyph share the result port.
// The sqrt chain (32 cells) and the three divide chains (31 cells each) advance
// together and hold while the vertex emitter is still busy with the previous glyph.
// Reset (aresetn low, synchronous) empties the chain and restores
// size_factor = 1.0 and offset_mode = 0.
`default_nettype none
module vector_cone_glyph_generator #(
    parameter int unsigned MAX_GLYPHS = vcg_pkg::MAX_GLYPHS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [vcg_pkg::SIZE_W-1:0]    cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [vcg_pkg::IDX_W-1:0]     s_glyph_index,
    input  wire logic signed [31:0]            s_point_x,
    input  wire logic signed [31:0]            s_point_y,
    input  wire logic signed [31:0]            s_point_z,
    input  wire logic signed [31:0]            s_dir_x,
    input  wire logic signed [31:0]            s_dir_y,
    input  wire logic signed [31:0]            s_dir_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [vcg_pkg::SLOT_W-1:0]         m_vertex_slot,
    output logic signed [31:0]                 m_vertex_x,
    output logic signed [31:0]                 m_vertex_y,
    output logic signed [31:0]                 m_vertex_z,
    output logic [vcg_pkg::SIZE_W-1:0]         m_vertex_radius,
    output logic                               m_last_vertex
);

    localparam int SQ_IX  = 1;
    localparam int SUM_IX = 2;
    localparam int MUL_IX = 3 + vcg_pkg::SQRT_STEPS;
    localparam int PIPE   = MUL_IX + 1 + vcg_pkg::DIV_STEPS;

    logic [vcg_pkg::SIZE_W-1:0] size_factor_reg;
    logic                       offset_mode_reg;
    logic                       adv;

    logic [PIPE-1:0]            vld_reg;
    vcg_pkg::item_t             itm_reg  [PIPE];
    vcg_pkg::item_t             itm_next [PIPE];

    logic [2:0][vcg_pkg::SQ_W-1:0]  sq_reg;
    logic [vcg_pkg::SQ_W-1:0]       sum_reg;
    logic [2:0][vcg_pkg::NUM_W-1:0] num_reg;

    logic [vcg_pkg::SQ_W-1:0]   sx   [vcg_pkg::SQRT_STEPS+1];
    logic [vcg_pkg::SREM_W-1:0] srem [vcg_pkg::SQRT_STEPS+1];
    logic [vcg_pkg::ROOT_W-1:0] sroot[vcg_pkg::SQRT_STEPS+1];

    logic [vcg_pkg::ROOT_W-1:0] drem [vcg_pkg::DIV_STEPS+1][3];
    logic [vcg_pkg::SIZE_W-1:0] dnum [vcg_pkg::DIV_STEPS+1][3];
    logic [vcg_pkg::SIZE_W-1:0] dq   [vcg_pkg::DIV_STEPS+1][3];

    vcg_pkg::glyph_t            glyph;
    logic                       in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_factor_reg <= vcg_pkg::SIZE_W'(65536);
            offset_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                vcg_pkg::CFG_SIZE_FACTOR: size_factor_reg <= cfg_data;
                vcg_pkg::CFG_OFFSET_MODE: offset_mode_reg <= cfg_data[0];
            endcase
        end
    end

    assign s_ready  = adv;
    assign in_range = (32'(s_glyph_index) < 32'(MAX_GLYPHS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE-2:0], s_valid && in_range};
        end
    end

    always_comb begin
        itm_next[0].idx    = s_glyph_index;
        itm_next[0].pnt[0] = s_point_x;
        itm_next[0].pnt[1] = s_point_y;
        itm_next[0].pnt[2] = s_point_z;
        itm_next[0].sgn    = {s_dir_z[31], s_dir_y[31], s_dir_x[31]};
        itm_next[0].mag[0] = s_dir_x[31] ? 32'(-s_dir_x) : s_dir_x;
        itm_next[0].mag[1] = s_dir_y[31] ? 32'(-s_dir_y) : s_dir_y;
        itm_next[0].mag[2] = s_dir_z[31] ? 32'(-s_dir_z) : s_dir_z;
        itm_next[0].deg    = 1'b0;
        itm_next[0].div    = '0;
        for (int i = 1; i < PIPE; i++) begin
            itm_next[i] = itm_reg[i-1];
        end
        itm_next[MUL_IX].deg = (sroot[vcg_pkg::SQRT_STEPS] == '0);
        itm_next[MUL_IX].div = (sroot[vcg_pkg::SQRT_STEPS] == '0) ?
                               vcg_pkg::ROOT_W'(1) : sroot[vcg_pkg::SQRT_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < PIPE; i++) begin
                itm_reg[i] <= itm_next[i];
            end
            for (int c = 0; c < 3; c++) begin
                sq_reg[c]  <= itm_reg[SQ_IX-1].mag[c] * itm_reg[SQ_IX-1].mag[c];
                num_reg[c] <= vcg_pkg::NUM_W'(size_factor_reg * itm_reg[MUL_IX-1].mag[c]);
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign sx[0]    = sum_reg;
    assign srem[0]  = '0;
    assign sroot[0] = '0;

    for (genvar j = 0; j < vcg_pkg::SQRT_STEPS; j++) begin : g_sqrt
        vcg_sqrt_cell u_cell (
            .aclk     (aclk),
            .en       (adv),
            .x_in     (sx[j]),
            .rem_in   (srem[j]),
            .root_in  (sroot[j]),
            .x_reg    (sx[j+1]),
            .rem_reg  (srem[j+1]),
            .root_reg (sroot[j+1])
        );
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
        assign drem[0][c] = {1'b0, num_reg[c][vcg_pkg::NUM_W-1:vcg_pkg::SIZE_W]};
        assign dnum[0][c] = num_reg[c][vcg_pkg::SIZE_W-1:0];
        assign dq[0][c]   = '0;
        for (genvar j = 0; j < vcg_pkg::DIV_STEPS; j++) begin : g_div
            vcg_div_cell u_cell (
                .aclk    (aclk),
                .en      (adv),
                .m_in    (itm_reg[MUL_IX+j].div),
                .rem_in  (drem[j][c]),
                .num_in  (dnum[j][c]),
                .q_in    (dq[j][c]),
                .rem_reg (drem[j+1][c]),
                .num_reg (dnum[j+1][c]),
                .q_reg   (dq[j+1][c])
            );
        end
        assign glyph.ofs[c] = itm_reg[PIPE-1].sgn[c] ?
                              32'(-{1'b0, dq[vcg_pkg::DIV_STEPS][c]}) :
                              {1'b0, dq[vcg_pkg::DIV_STEPS][c]};
    end

    assign glyph.idx = itm_reg[PIPE-1].idx;
    assign glyph.pnt = itm_reg[PIPE-1].pnt;
    assign glyph.deg = itm_reg[PIPE-1].deg;

    vcg_emit u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (vld_reg[PIPE-1]),
        .in_glyph        (glyph),
        .size_factor     (size_factor_reg),
        .offset_mode     (offset_mode_reg),
        .load            (adv),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertex_slot   (m_vertex_slot),
        .m_vertex_x      (m_vertex_x),
        .m_vertex_y      (m_vertex_y),
        .m_vertex_z      (m_vertex_z),
        .m_vertex_radius (m_vertex_radius),
        .m_last_vertex   (m_last_vertex)
    );

endmodule
`default_nettype wire

// ----- rtl/vcg_checker.sv -----
`default_nettype none
module vcg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [17:0] m_vertex_slot,
    input wire logic [30:0] m_vertex_radius,
    input wire logic        m_last_vertex
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vertex_slot))
        else $error("result item dropped while stalled");

    a_next_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_vertex |=>
            m_valid && m_vertex_slot == $past(m_vertex_slot) + 18'd1)
        else $error("vertex slot sequence broken");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_last_vertex == (m_vertex_slot[1:0] == 2'd3))
        else $error("last vertex flag out of step with slot");

    a_tip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_vertex |-> m_vertex_radius == '0)
        else $error("cone tip radius not zero");

endmodule

bind vector_cone_glyph_generator vcg_checker u_vcg_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_vertex_slot   (m_vertex_slot),
    .m_vertex_radius (m_vertex_radius),
    .m_last_vertex   (m_last_vertex)
);
`default_nettype wire
